>>> design/i2c_bus_error_recovery_assert.svh
// Assertion macros for the bus recovery block.
// Each macro checks one property against clk_i with reset rst_ni held off.
`ifndef I2C_BUS_ERROR_RECOVERY_ASSERT_SVH
`define I2C_BUS_ERROR_RECOVERY_ASSERT_SVH

// same-cycle implication
`define I2CBER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CBER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/i2cber_pkg.sv
package i2cber_pkg;

  localparam int unsigned HalfW    = 16;
  localparam int unsigned ClkW     = 4;
  localparam int unsigned AttW     = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [HalfW-1:0] HalfPeriodRst = 16'd5;
  localparam logic [ClkW-1:0]  MaxClocksRst  = 4'd9;
  localparam logic [AttW-1:0]  AttLimitRst   = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_PERIOD = 2'd0,
    CFG_MAX_CLOCKS  = 2'd1,
    CFG_ATT_LIMIT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_CLK_LOW       = 3'd1,
    PH_CLK_HIGH      = 3'd2,
    PH_STOP_SCL_LOW  = 3'd3,
    PH_STOP_SDA_LOW  = 3'd4,
    PH_STOP_SCL_HIGH = 3'd5,
    PH_STOP_SDA_HIGH = 3'd6
  } phase_e;

  typedef struct packed {
    logic [HalfW-1:0] half_period_ticks;
    logic [ClkW-1:0]  max_recovery_clocks;
    logic [AttW-1:0]  attempts_limit;
  } cfg_t;

  typedef struct packed {
    logic            recovery_active;
    logic            scl_level;
    logic            sda_output_enable;
    logic            sda_level_res;
    logic            reinit_request;
    logic            error_ignored;
    logic [AttW-1:0] attempts_seen;
  } res_t;

endpackage

>>> design/i2cber_core.sv
module i2cber_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                cmd_i,
  input  logic                sda_level_i,
  input  i2cber_pkg::cfg_t    cfg_i,
  output i2cber_pkg::res_t    res_o
);
  import i2cber_pkg::*;

  phase_e            phase_q, phase_d;
  logic [HalfW-1:0]  timer_q, timer_d;
  logic [ClkW-1:0]   pulses_q, pulses_d;
  logic [AttW-1:0]   att_q, att_d;
  logic              reinit, ignored;
  logic [HalfW:0]    timer_inc;
  logic              phase_done;
  logic [ClkW-1:0]   pulses_inc;
  logic [AttW-1:0]   att_inc;

  assign timer_inc  = {1'b0, timer_q} + {{HalfW{1'b0}}, 1'b1};
  assign phase_done = timer_inc >= {1'b0, cfg_i.half_period_ticks};
  assign pulses_inc = pulses_q + {{(ClkW-1){1'b0}}, 1'b1};
  assign att_inc    = att_q + {{(AttW-1){1'b0}}, 1'b1};

  // next state
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    pulses_d = pulses_q;
    att_d = att_q;
    reinit = 1'b0;
    ignored = 1'b0;
    if (cmd_i) begin
      if (phase_q != PH_IDLE) begin
        ignored = 1'b1;
      end else if (att_inc >= cfg_i.attempts_limit) begin
        att_d = '0;
        pulses_d = '0;
        phase_d = PH_CLK_LOW;
        timer_d = '0;
      end else begin
        att_d = att_inc;
        reinit = 1'b1;
      end
    end else if (phase_q != PH_IDLE) begin
      if (phase_done) begin
        timer_d = '0;
        case (phase_q)
          PH_CLK_LOW:       phase_d = PH_CLK_HIGH;
          PH_CLK_HIGH: begin
            pulses_d = pulses_inc;
            if (sda_level_i || (pulses_inc >= cfg_i.max_recovery_clocks)) begin
              phase_d = PH_STOP_SCL_LOW;
            end else begin
              phase_d = PH_CLK_LOW;
            end
          end
          PH_STOP_SCL_LOW:  phase_d = PH_STOP_SDA_LOW;
          PH_STOP_SDA_LOW:  phase_d = PH_STOP_SCL_HIGH;
          PH_STOP_SCL_HIGH: phase_d = PH_STOP_SDA_HIGH;
          default: begin
            phase_d = PH_IDLE;
            reinit = 1'b1;
          end
        endcase
      end else begin
        timer_d = timer_inc[HalfW-1:0];
      end
    end
  end

  // pin levels follow the phase after this transfer
  always_comb begin
    res_o = '0;
    res_o.recovery_active = (phase_d != PH_IDLE);
    res_o.reinit_request = reinit;
    res_o.error_ignored = ignored;
    res_o.attempts_seen = att_d;
    case (phase_d)
      PH_CLK_LOW:       res_o.scl_level = 1'b0;
      PH_CLK_HIGH:      res_o.scl_level = 1'b1;
      PH_STOP_SCL_LOW:  res_o.scl_level = 1'b0;
      PH_STOP_SDA_LOW: begin
        res_o.scl_level = 1'b0;
        res_o.sda_output_enable = 1'b1;
      end
      PH_STOP_SCL_HIGH: begin
        res_o.scl_level = 1'b1;
        res_o.sda_output_enable = 1'b1;
      end
      PH_STOP_SDA_HIGH: begin
        res_o.scl_level = 1'b1;
        res_o.sda_output_enable = 1'b1;
        res_o.sda_level_res = 1'b1;
      end
      default:          res_o.scl_level = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      pulses_q <= '0;
      att_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      pulses_q <= pulses_d;
      att_q <= att_d;
    end
  end

endmodule

>>> design/i2c_bus_error_recovery.sv
// Result: each accepted transfer's result is on the output register the next cycle.
// Throughput: one item per cycle; the next item is taken while a result waits,
// as long as the output register is empty or is being read in the same cycle.
// Reset: phase idle, timer, pulse and attempt counts cleared, registers at their
// package defaults (at most 9 SCL pulses, limit 4), no result pending.
module i2c_bus_error_recovery (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [i2cber_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [i2cber_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  cmd_i,
  input  logic                                  sda_level_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  recovery_active_o,
  output logic                                  scl_level_o,
  output logic                                  sda_output_enable_o,
  output logic                                  sda_level_res_o,
  output logic                                  reinit_request_o,
  output logic                                  error_ignored_o,
  output logic [i2cber_pkg::AttW-1:0]           attempts_seen_o
);
  import i2cber_pkg::*;

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= HalfPeriodRst;
      cfg_q.max_recovery_clocks <= MaxClocksRst;
      cfg_q.attempts_limit <= AttLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data_i[HalfW-1:0];
        CFG_MAX_CLOCKS:  cfg_q.max_recovery_clocks <= cfg_data_i[ClkW-1:0];
        CFG_ATT_LIMIT:   cfg_q.attempts_limit <= cfg_data_i[AttW-1:0];
        default: ;
      endcase
    end
  end

  i2cber_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .cmd_i       (cmd_i),
    .sda_level_i (sda_level_i),
    .cfg_i       (cfg_q),
    .res_o       (res_d)
  );

  // hold the result until the transfer out completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign recovery_active_o   = res_q.recovery_active;
  assign scl_level_o         = res_q.scl_level;
  assign sda_output_enable_o = res_q.sda_output_enable;
  assign sda_level_res_o     = res_q.sda_level_res;
  assign reinit_request_o    = res_q.reinit_request;
  assign error_ignored_o     = res_q.error_ignored;
  assign attempts_seen_o     = res_q.attempts_seen;

`include "i2c_bus_error_recovery_assert.svh"

  `I2CBER_ASSERT_NOW(a_idle_pins, out_valid_o && !recovery_active_o, scl_level_o && !sda_output_enable_o, "idle result drives pins")
  `I2CBER_ASSERT_NOW(a_sda_released, out_valid_o && !sda_output_enable_o, !sda_level_res_o, "released SDA with level set")
  `I2CBER_ASSERT_NOW(a_ignored_busy, out_valid_o && error_ignored_o, recovery_active_o && !reinit_request_o, "ignored error outside recovery")
  `I2CBER_ASSERT_NOW(a_stall_full, in_valid_i && !in_ready_o, out_valid_o, "input stalled with empty output")
  `I2CBER_ASSERT_NEXT(a_accept_fills, in_accept, out_valid_o, "accepted item left no result")

endmodule
